### rtl/core/sps_pkg.sv
`timescale 1ns / 1ps
package sps_pkg;
	localparam int CordicSteps = 16;
	localparam int LitLevel = 154;
	localparam int BlueMix = 154;
	localparam logic [31:0] HalfTurn = 32'h8000_0000;

	typedef enum logic [5:0] {
		REG_FRAME_WIDTH  = 6'd0,
		REG_FRAME_HEIGHT = 6'd1,
		REG_COLOR_MODE   = 6'd2,
		REG_INTENSITY    = 6'd3,
		REG_PHASE_STEP   = 6'd4,
		REG_RADIAL_STEP  = 6'd5
	} reg_index_t;

	// Arctangent of 2^-i, in 2^32 units per turn.
	function automatic logic [31:0] turn_atan(input logic [3:0] i);
		case (i)
			4'd0: turn_atan = 32'd536870912;
			4'd1: turn_atan = 32'd316933406;
			4'd2: turn_atan = 32'd167458907;
			4'd3: turn_atan = 32'd85004756;
			4'd4: turn_atan = 32'd42667331;
			4'd5: turn_atan = 32'd21354465;
			4'd6: turn_atan = 32'd10679838;
			4'd7: turn_atan = 32'd5340245;
			4'd8: turn_atan = 32'd2670163;
			4'd9: turn_atan = 32'd1335087;
			4'd10: turn_atan = 32'd667544;
			4'd11: turn_atan = 32'd333772;
			4'd12: turn_atan = 32'd166886;
			4'd13: turn_atan = 32'd83443;
			4'd14: turn_atan = 32'd41722;
			default: turn_atan = 32'd20861;
		endcase
	endfunction

	// Side data that rides along the pipeline with each pixel.
	typedef struct packed {
		logic [7:0] led_index;
		logic       in_frame;
		logic [1:0] mode;
		logic [7:0] intensity;
	} side_t;
endpackage

### rtl/core/sps_vec_cell.sv
`timescale 1ns / 1ps
// One vectoring CORDIC step for the angle, with one square-root digit beside it.
module sps_vec_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [23:0] x_in,
	input  logic signed [23:0] y_in,
	input  logic        [31:0] z_in,
	input  logic        [31:0] rv_in,
	input  logic        [31:0] rr_in,
	output logic signed [23:0] x_out,
	output logic signed [23:0] y_out,
	output logic        [31:0] z_out,
	output logic        [31:0] rv_out,
	output logic        [31:0] rr_out
);
	localparam logic [31:0] RootBit = 32'h4000_0000 >> (2 * STEP);
	logic signed [23:0] xs, ys;
	logic [31:0] trial;

	assign xs = x_in >>> STEP;
	assign ys = y_in >>> STEP;
	assign trial = rr_in + RootBit;

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in > 0) begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				z_out <= z_in + sps_pkg::turn_atan(4'(STEP));
			end else begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				z_out <= z_in - sps_pkg::turn_atan(4'(STEP));
			end
			if (rv_in >= trial) begin
				rv_out <= rv_in - trial;
				rr_out <= (rr_in >> 1) + RootBit;
			end else begin
				rv_out <= rv_in;
				rr_out <= rr_in >> 1;
			end
		end
	end
endmodule

### rtl/core/sps_rot_cell.sv
`timescale 1ns / 1ps
// One rotation CORDIC step for the cosine.
module sps_rot_cell #(
	parameter int STEP = 0
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [19:0] x_in,
	input  logic signed [19:0] y_in,
	input  logic signed [32:0] s_in,
	output logic signed [19:0] x_out,
	output logic signed [19:0] y_out,
	output logic signed [32:0] s_out
);
	logic signed [19:0] xs, ys;
	logic signed [32:0] a;

	assign xs = x_in >>> STEP;
	assign ys = y_in >>> STEP;
	assign a = $signed({1'b0, sps_pkg::turn_atan(4'(STEP))});

	always_ff @(posedge clk) begin
		if (en) begin
			if (s_in >= 0) begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				s_out <= s_in - a;
			end else begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				s_out <= s_in + a;
			end
		end
	end
endmodule

### rtl/core/spiral_pattern_pixel_shader_unit.sv
`timescale 1ns / 1ps
// Spiral shader: takes one pixel request per clock unless stalled and returns one result per
// pixel, in order. The pipeline stalls as a whole only while the output register holds a
// result that is not taken. It is built from two chains of sixteen CORDIC cells
// (angle with square root, then cosine) plus multiply stages between and after them.
// The phase offset advances when a pixel flagged end of frame enters.
module spiral_pattern_pixel_shader_unit #(
	parameter int MAX_WIDTH = 16,
	parameter int MAX_HEIGHT = 16,
	parameter int PHASE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  col,
	input  logic [3:0]  row,
	input  logic        end_of_frame,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  led_index,
	output logic        lit,
	output logic [7:0]  red,
	output logic [7:0]  blue
);
	localparam int N = sps_pkg::CordicSteps;
	// Stages: 0 entry, 1..16 vector cells, 17 angle, 18 radial mul, 19 phase,
	// 20 fold, 21..36 rotation cells, 37 bright, 38..39 mul, 40 output.
	localparam int Depth = 2 * N + 9;
	localparam int VecEnd = N;
	localparam logic [PHASE_BITS-1:0] PhaseMask = {PHASE_BITS{1'b1}};

	logic [4:0] width_q, height_q;
	logic [1:0] mode_q;
	logic [7:0] intensity_q;
	logic [15:0] phase_step_q;
	logic [23:0] radial_step_q;
	logic [PHASE_BITS-1:0] offset_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 5'd16;
			height_q <= 5'd16;
			mode_q <= 2'd0;
			intensity_q <= 8'd255;
			phase_step_q <= 16'd1024;
			radial_step_q <= 24'd2670177;
		end else if (cfg_we) begin
			case (cfg_index)
				sps_pkg::REG_FRAME_WIDTH: width_q <= cfg_data[4:0];
				sps_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data[4:0];
				sps_pkg::REG_COLOR_MODE: mode_q <= cfg_data[1:0];
				sps_pkg::REG_INTENSITY: intensity_q <= cfg_data[7:0];
				sps_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data[15:0];
				sps_pkg::REG_RADIAL_STEP: radial_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Global stall: the whole pipe moves when the output slot is empty or its result is taken.
	logic [Depth-1:0] vld_q;
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			offset_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
			if (in_valid && end_of_frame)
				offset_q <= offset_q + PHASE_BITS'(phase_step_q);
		end
	end
	assign out_valid = vld_q[Depth-1];

	// Entry stage: offsets, LED index and side data.
	logic [4:0] w, h;
	logic signed [6:0] dx, dy;
	logic signed [12:0] dx_w, dy_w;
	logic [12:0] sq;
	logic [7:0] idx_full;
	assign w = (32'(width_q) > MAX_WIDTH) ? 5'(MAX_WIDTH) : width_q;
	assign h = (32'(height_q) > MAX_HEIGHT) ? 5'(MAX_HEIGHT) : height_q;
	assign dx = $signed({2'b0, col, 1'b0}) - $signed({2'b0, w}) + 7'sd1;
	assign dy = $signed({2'b0, row, 1'b0}) - $signed({2'b0, h}) + 7'sd1;
	assign dx_w = 13'(dx);
	assign dy_w = 13'(dy);
	assign sq = 13'(dx_w * dx_w + dy_w * dy_w);
	assign idx_full = row[0] ? 8'(row) * 8'(w) + 8'(w) - 8'd1 - 8'(col)
		: 8'(row) * 8'(w) + 8'(col);

	sps_pkg::side_t side_q [Depth];
	logic [PHASE_BITS-1:0] off_q [Depth];
	logic zero_q [Depth];
	logic signed [23:0] vx [N+1];
	logic signed [23:0] vy [N+1];
	logic [31:0] vz [N+1];
	logic [31:0] rv [N+1];
	logic [31:0] rr [N+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0].led_index <= idx_full;
			side_q[0].in_frame <= (5'(col) < w) && (5'(row) < h);
			side_q[0].mode <= (mode_q == 2'd3) ? 2'd0 : mode_q;
			side_q[0].intensity <= intensity_q;
			off_q[0] <= offset_q;
			zero_q[0] <= (dx == 0) && (dy == 0);
			if (dx < 0) begin
				vx[0] <= -(24'(dx) <<< 16);
				vy[0] <= -(24'(dy) <<< 16);
				vz[0] <= sps_pkg::HalfTurn;
			end else begin
				vx[0] <= 24'(dx) <<< 16;
				vy[0] <= 24'(dy) <<< 16;
				vz[0] <= '0;
			end
			rv[0] <= {5'b0, sq, 14'b0};
			rr[0] <= '0;
			for (int k = 1; k < Depth; k++) begin
				side_q[k] <= side_q[k-1];
				off_q[k] <= off_q[k-1];
				zero_q[k] <= zero_q[k-1];
			end
		end
	end

	// Angle and distance chain.
	for (genvar g = 0; g < N; g++) begin : g_vec
		sps_vec_cell #(.STEP(g)) u_cell (
			.clk(clk), .en(adv),
			.x_in(vx[g]), .y_in(vy[g]), .z_in(vz[g]), .rv_in(rv[g]), .rr_in(rr[g]),
			.x_out(vx[g+1]), .y_out(vy[g+1]), .z_out(vz[g+1]),
			.rv_out(rv[g+1]), .rr_out(rr[g+1])
		);
	end

	// Radial term and phase.
	logic [PHASE_BITS-1:0] ang_s17, ang_s18, phase_s19;
	logic [15:0] dist_s17;
	logic [39:0] rad_s18;
	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s17 <= zero_q[VecEnd] ? '0 : vz[N][31 -: PHASE_BITS];
			dist_s17 <= rr[N][15:0];
			ang_s18 <= ang_s17;
			rad_s18 <= 40'(radial_step_q) * 40'(dist_s17);
			phase_s19 <= (ang_s18 + PHASE_BITS'(rad_s18[39:16]) + off_q[VecEnd+2])
				& PhaseMask;
		end
	end

	// Quadrant fold into the rotation chain.
	logic [31:0] theta;
	logic signed [32:0] sfull;
	logic signed [19:0] cx [N+1];
	logic signed [19:0] cy [N+1];
	logic signed [32:0] cs [N+1];
	logic flip_q [N+1];
	assign theta = {phase_s19, {(32-PHASE_BITS){1'b0}}};
	assign sfull = $signed({theta[31], theta});
	always_ff @(posedge clk) begin
		if (adv) begin
			cx[0] <= 20'sd39797;
			cy[0] <= '0;
			if (sfull > 33'sd1073741824) begin
				cs[0] <= sfull - 33'sd2147483648;
				flip_q[0] <= 1'b1;
			end else if (sfull < -33'sd1073741824) begin
				cs[0] <= sfull + 33'sd2147483648;
				flip_q[0] <= 1'b1;
			end else begin
				cs[0] <= sfull;
				flip_q[0] <= 1'b0;
			end
			for (int k = 1; k <= N; k++) flip_q[k] <= flip_q[k-1];
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_rot
		sps_rot_cell #(.STEP(g)) u_cell (
			.clk(clk), .en(adv),
			.x_in(cx[g]), .y_in(cy[g]), .s_in(cs[g]),
			.x_out(cx[g+1]), .y_out(cy[g+1]), .s_out(cs[g+1])
		);
	end

	// Brightness, levels and output register.
	localparam int SB = 2 * N + 5;
	logic signed [20:0] cval, bv;
	logic [7:0] b_s37;
	logic [15:0] prod_s38;
	logic [7:0] b_s38;
	logic [23:0] mix_s39;
	logic [7:0] lvl_s39;
	logic lit_s39;
	assign cval = flip_q[N] ? -21'(cx[N]) : 21'(cx[N]);
	assign bv = cval + 21'sd65536;
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s37 <= (bv < 0) ? 8'd0 : ((bv >>> 9) > 255 ? 8'd255 : 8'(bv >>> 9));
			b_s38 <= b_s37;
			prod_s38 <= 16'(b_s37) * 16'(side_q[SB].intensity);
			lvl_s39 <= prod_s38[15:8];
			mix_s39 <= 24'(prod_s38) * 24'(sps_pkg::BlueMix);
			lit_s39 <= side_q[SB+1].in_frame && (b_s38 >= 8'(sps_pkg::LitLevel));
			led_index <= side_q[SB+2].led_index;
			lit <= lit_s39;
			red <= (lit_s39 && side_q[SB+2].mode != 2'd0) ? lvl_s39 : 8'd0;
			blue <= !lit_s39 ? 8'd0 :
				(side_q[SB+2].mode == 2'd0) ? lvl_s39 :
				(side_q[SB+2].mode == 2'd2) ? mix_s39[23:16] : 8'd0;
		end
	end
endmodule

### rtl/core/sps_checker.sv
`timescale 1ns / 1ps
module sps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       lit,
	input logic [7:0] red,
	input logic [7:0] blue
);
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !lit |-> red == 8'd0 && blue == 8'd0)
		else $error("unlit pixel carries color");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(blue))
		else $error("stalled result changed");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
endmodule

bind spiral_pattern_pixel_shader_unit sps_checker u_sps_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .lit(lit), .red(red), .blue(blue)
);

### tb/sv/tb_spiral_pattern_pixel_shader_unit.sv
`timescale 1ns / 1ps
module tb_spiral_pattern_pixel_shader_unit;
	typedef struct packed {
		logic [7:0] led_index;
		logic       lit;
		logic [7:0] red;
		logic [7:0] blue;
	} shade_t;

	// Shader model and store of the shades still owed by the block.
	class shade_scoreboard;
		bit [4:0]  width_reg, height_reg;
		bit [1:0]  mode_reg;
		bit [7:0]  level_reg;
		bit [15:0] step_reg, offset;
		bit [23:0] radial_reg;
		shade_t    owed[$];
		int        errors;
		bit [31:0] atan_tab[16];

		function new();
			atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
				10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
				41722, 20861};
			width_reg = 16; height_reg = 16; mode_reg = 0; level_reg = 255;
			step_reg = 1024; radial_reg = 2670177; offset = 0; errors = 0;
		endfunction

		function void set_reg(sps_pkg::reg_index_t idx, bit [23:0] v);
			case (idx)
				sps_pkg::REG_FRAME_WIDTH: width_reg = v[4:0];
				sps_pkg::REG_FRAME_HEIGHT: height_reg = v[4:0];
				sps_pkg::REG_COLOR_MODE: mode_reg = v[1:0];
				sps_pkg::REG_INTENSITY: level_reg = v[7:0];
				sps_pkg::REG_PHASE_STEP: step_reg = v[15:0];
				sps_pkg::REG_RADIAL_STEP: radial_reg = v;
				default: ;
			endcase
		endfunction

		function bit [31:0] isqrt(bit [31:0] v);
			bit [31:0] res, b;
			res = 0;
			b = 32'h4000_0000;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		// Vectoring rotation: angle of (dx, dy) in 2^32 units per turn.
		function bit [31:0] vector_angle(int dx, int dy);
			longint x, y, xs, ys;
			bit [31:0] z;
			x = longint'(dx) * 65536;
			y = longint'(dy) * 65536;
			z = 0;
			if (dx == 0 && dy == 0) return 0;
			if (x < 0) begin
				x = -x; y = -y; z = 32'h8000_0000;
			end
			for (int i = 0; i < 16; i++) begin
				xs = x >>> i; ys = y >>> i;
				if (y > 0) begin
					x = x + ys; y = y - xs; z = z + atan_tab[i];
				end else begin
					x = x - ys; y = y + xs; z = z - atan_tab[i];
				end
			end
			return z;
		endfunction

		// Rotation-mode cosine in Q16 with the quadrant folded in.
		function longint cosine(bit [31:0] th);
			longint s, x, y, xs, ys;
			bit flip;
			s = th < 32'h8000_0000 ? longint'(th) : longint'(th) - 64'sd4294967296;
			x = 39797; y = 0; flip = 0;
			if (s > 64'sd1073741824) begin
				s = s - 64'sd2147483648; flip = 1;
			end else if (s < -64'sd1073741824) begin
				s = s + 64'sd2147483648; flip = 1;
			end
			for (int i = 0; i < 16; i++) begin
				xs = x >>> i; ys = y >>> i;
				if (s >= 0) begin
					x = x - ys; y = y + xs; s = s - longint'(atan_tab[i]);
				end else begin
					x = x + ys; y = y - xs; s = s + longint'(atan_tab[i]);
				end
			end
			return flip ? -x : x;
		endfunction

		function void note_pixel(bit [3:0] c, bit [3:0] r, bit eof);
			int w, h, dx, dy, idx;
			bit [31:0] dist_v, ang, radial, phase, b, lvl;
			longint bv;
			shade_t s;
			w = width_reg > 16 ? 16 : width_reg;
			h = height_reg > 16 ? 16 : height_reg;
			dx = 2 * c - (w - 1);
			dy = 2 * r - (h - 1);
			dist_v = isqrt((dx * dx + dy * dy) << 14);
			ang = vector_angle(dx, dy) >> 16;
			radial = 32'((longint'(radial_reg) * dist_v) >> 16);
			phase = (ang + radial + offset) & 32'hFFFF;
			bv = cosine(phase << 16) + 65536;
			b = bv < 0 ? 0 : 32'(bv >> 9);
			if (b > 255) b = 255;
			idx = r[0] ? r * w + (w - 1 - c) : r * w + c;
			s = '0;
			s.led_index = idx[7:0];
			if (c < w && r < h && b >= sps_pkg::LitLevel) begin
				lvl = (b * level_reg) >> 8;
				s.lit = 1;
				case (mode_reg % 3)
					0: s.blue = lvl[7:0];
					1: s.red = lvl[7:0];
					default: begin
						s.red = lvl[7:0];
						s.blue = 8'((b * level_reg * sps_pkg::BlueMix) >> 16);
					end
				endcase
			end
			owed.push_back(s);
			if (eof) offset = offset + step_reg;
		endfunction

		function void check_shade(shade_t got);
			shade_t exp_s;
			if (owed.size() == 0) begin
				$error("unexpected result led_index=%0d", got.led_index);
				errors++;
				return;
			end
			exp_s = owed.pop_front();
			if (got.led_index !== exp_s.led_index) begin
				$error("led_index expected %0d actual %0d", exp_s.led_index, got.led_index);
				errors++;
			end
			if (got.lit !== exp_s.lit) begin
				$error("lit expected %0d actual %0d", exp_s.lit, got.lit);
				errors++;
			end
			if (got.red !== exp_s.red) begin
				$error("red expected %0d actual %0d", exp_s.red, got.red);
				errors++;
			end
			if (got.blue !== exp_s.blue) begin
				$error("blue expected %0d actual %0d", exp_s.blue, got.blue);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n, cfg_we, in_valid, in_ready, end_of_frame, out_valid, out_ready;
	logic [5:0]  cfg_index;
	logic [23:0] cfg_data;
	logic [3:0]  col, row;
	logic [7:0]  led_index, red, blue;
	logic        lit;

	shade_scoreboard sb = new();
	bit  idle_on = 1;
	int  hold_cycles = 0;
	int  quiet = 0;

	spiral_pattern_pixel_shader_unit dut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Receiver: random stalls, with an optional long hold-off.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
		end
	end

	// Accepted requests feed the model, accepted results are checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_pixel(col, row, end_of_frame);
			if (out_valid && out_ready) sb.check_shade({led_index, lit, red, blue});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= 5000) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_pixel(bit [3:0] c, bit [3:0] r, bit eof);
		while (idle_on && $urandom_range(99) < 33) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		col <= c;
		row <= r;
		end_of_frame <= eof;
		do @(posedge clk); while (!in_ready);
	endtask

	// Let the pipeline drain so registers change only while idle.
	task automatic drain();
		in_valid <= 0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(sps_pkg::reg_index_t idx, bit [23:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, v);
	endtask

	task automatic configure(int w, int h, int m, int lvl, int ps, int rs);
		write_reg(sps_pkg::REG_FRAME_WIDTH, 24'(w));
		write_reg(sps_pkg::REG_FRAME_HEIGHT, 24'(h));
		write_reg(sps_pkg::REG_COLOR_MODE, 24'(m));
		write_reg(sps_pkg::REG_INTENSITY, 24'(lvl));
		write_reg(sps_pkg::REG_PHASE_STEP, 24'(ps));
		write_reg(sps_pkg::REG_RADIAL_STEP, 24'(rs));
	endtask

	// Mostly pixels inside the frame, some anywhere, end of frame now and then.
	task automatic random_pixels(int n);
		int w, h;
		bit [3:0] c, r;
		w = sb.width_reg > 16 ? 16 : sb.width_reg;
		h = sb.height_reg > 16 ? 16 : sb.height_reg;
		for (int i = 0; i < n; i++) begin
			if (w > 0 && h > 0 && $urandom_range(99) < 70) begin
				c = 4'($urandom_range(w - 1));
				r = 4'($urandom_range(h - 1));
			end else begin
				c = 4'($urandom);
				r = 4'($urandom);
			end
			send_pixel(c, r, $urandom_range(15) == 0);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; col = 0; row = 0; end_of_frame = 0; out_ready = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: corners, center, out-of-frame pixels, frame ends.
		send_pixel(0, 0, 0);
		send_pixel(15, 15, 0);
		send_pixel(0, 15, 0);
		send_pixel(15, 0, 1);
		send_pixel(7, 7, 0);
		send_pixel(8, 8, 1);
		send_pixel(1, 1, 0);
		send_pixel(14, 3, 0);
		drain();
		configure(3, 5, 1, 200, 65535, 16777215);
		send_pixel(1, 2, 0);
		send_pixel(4, 2, 0);
		send_pixel(2, 7, 1);
		send_pixel(0, 1, 0);
		send_pixel(15, 15, 1);
		send_pixel(2, 4, 0);
		drain();
		configure(0, 0, 2, 0, 0, 0);
		send_pixel(0, 0, 1);
		send_pixel(15, 15, 0);
		drain();
		configure(31, 31, 3, 255, 12345, 0);
		send_pixel(15, 15, 1);
		send_pixel(10, 5, 1);
		drain();

		// Random phases across several settings.
		configure(16, 16, 2, 255, 1024, 2670177);
		random_pixels(100);
		drain();
		configure(1, 1, 0, 128, 40000, 16777215);
		random_pixels(60);
		drain();
		configure(9, 12, 1, 77, 3000, 1234567);
		random_pixels(100);
		drain();

		// No idling, then a long receiver hold-off while requests keep coming.
		configure(16, 16, 3, 255, 700, 5000000);
		idle_on = 0;
		random_pixels(80);
		hold_cycles = 200;
		random_pixels(100);
		idle_on = 1;
		drain();
		configure(31, 7, 2, 1, 65535, 9999999);
		random_pixels(80);
		drain();
		configure(5, 31, 0, 255, 0, 2670177);
		random_pixels(80);
		drain();

		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

### sim.f
rtl/core/sps_pkg.sv
rtl/core/sps_vec_cell.sv
rtl/core/sps_rot_cell.sv
rtl/core/spiral_pattern_pixel_shader_unit.sv
rtl/core/sps_checker.sv
tb/sv/tb_spiral_pattern_pixel_shader_unit.sv
